FILE: rtl/cgr_pkg.sv
// ----------------------------------------------------------------------------
// cgr_pkg
// Shared types and constants of the color gradient ramp: controller states,
// divider operand select, command and status bundles.
// ----------------------------------------------------------------------------
package cgr_pkg;

    localparam int MAX_STOPS   = 16;
    localparam int MAX_ENTRIES = 64;

    localparam int CHAN_W  = 16;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int CC_W    = 5;
    localparam int SEEN_W  = 5;
    localparam int SEG_W   = 4;
    localparam int CFG_W   = 7;
    localparam int DIV_W   = 16;
    localparam int DIV_CNT_W = 4;

    localparam logic REG_COLOR_COUNT = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SEG,
        ST_PREP,
        ST_EMIT,
        ST_FINISH
    } cgr_state_t;

    typedef enum logic [1:0] {
        DIV_BASE,
        DIV_RED,
        DIV_GREEN,
        DIV_BLUE
    } cgr_div_sel_t;

    typedef struct packed {
        logic         take;
        logic         div_start;
        logic         div_store;
        cgr_div_sel_t div_sel;
        logic         seg_load;
        logic         emit_init;
        logic         emit_next;
        logic         commit;
    } cgr_cmd_t;

    typedef struct packed {
        logic first_stop;
        logic div_done;
        logic len_zero;
        logic last_entry;
    } cgr_status_t;

endpackage

FILE: rtl/cgr_div.sv
// ----------------------------------------------------------------------------
// cgr_div
// Restoring unsigned divider, one quotient bit per cycle. Quotient is valid
// from the done pulse until the next start.
// ----------------------------------------------------------------------------
module cgr_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cgr_pkg::DIV_W-1:0] dividend,
    input  logic [cgr_pkg::LEN_W-1:0] divisor,
    output logic                      done,
    output logic [cgr_pkg::DIV_W-1:0] quotient
);
    import cgr_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [LEN_W:0]       rem_reg;
    logic [LEN_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [LEN_W:0] shifted;
    logic [LEN_W:0] trial;
    logic           ge;

    assign shifted = {rem_reg[LEN_W-1:0], quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial : shifted;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/cgr_datapath.sv
// ----------------------------------------------------------------------------
// cgr_datapath
// Configuration registers, stop storage, segment length and per-channel step
// computation through a shared divider, and the entry accumulators.
// ----------------------------------------------------------------------------
module cgr_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [cgr_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic [cgr_pkg::CHAN_W-1:0] red_in,
    input  logic [cgr_pkg::CHAN_W-1:0] green_in,
    input  logic [cgr_pkg::CHAN_W-1:0] blue_in,
    input  cgr_pkg::cgr_cmd_t          cmd,
    output cgr_pkg::cgr_status_t       status,
    output logic [cgr_pkg::CHAN_W-1:0] red_out,
    output logic [cgr_pkg::CHAN_W-1:0] green_out,
    output logic [cgr_pkg::CHAN_W-1:0] blue_out,
    output logic [cgr_pkg::IDX_W-1:0]  entry_index,
    output logic                       segment_end,
    output logic                       gradient_end
);
    import cgr_pkg::*;

    logic [CC_W-1:0]   cc_reg;
    logic [LEN_W-1:0]  ec_reg;
    logic [SEEN_W-1:0] seen_reg;

    logic [CHAN_W-1:0] prev_r_reg, prev_g_reg, prev_b_reg;
    logic [CHAN_W-1:0] cur_r_reg, cur_g_reg, cur_b_reg;
    logic [CHAN_W-1:0] step_r_reg, step_g_reg, step_b_reg;
    logic [CHAN_W-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [LEN_W-1:0]  base_reg;
    logic [LEN_W-1:0]  start_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  remain_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_seg_reg;

    logic [CC_W-1:0]        n_stops;
    logic [LEN_W-1:0]       total;
    logic [SEEN_W-1:0]      seg;
    logic [SEG_W+LEN_W-1:0] prod;
    logic [LEN_W-1:0]       start_c;
    logic [LEN_W-1:0]       len_c;
    logic                   last_seg_c;
    logic                   neg_r, neg_g, neg_b;
    logic [CHAN_W-1:0]      mag_r, mag_g, mag_b;
    logic [DIV_W-1:0]       dividend;
    logic [LEN_W-1:0]       divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       quotient;
    logic [CHAN_W-1:0]      q_neg;

    // clamped register values
    always_comb begin
        if (cc_reg < CC_W'(2))
            n_stops = CC_W'(2);
        else if (cc_reg > CC_W'(MAX_STOPS))
            n_stops = CC_W'(MAX_STOPS);
        else
            n_stops = cc_reg;
        if (ec_reg == '0)
            total = LEN_W'(1);
        else if (ec_reg > LEN_W'(MAX_ENTRIES))
            total = LEN_W'(MAX_ENTRIES);
        else
            total = ec_reg;
    end

    assign seg        = seen_reg - 1'b1;
    assign prod       = (SEG_W+LEN_W)'(seg[SEG_W-1:0]) * (SEG_W+LEN_W)'(base_reg);
    assign start_c    = prod[LEN_W-1:0];
    assign last_seg_c = seg == (n_stops - CC_W'(2));
    assign len_c      = last_seg_c ? (total - start_c) : base_reg;

    assign neg_r = cur_r_reg < prev_r_reg;
    assign neg_g = cur_g_reg < prev_g_reg;
    assign neg_b = cur_b_reg < prev_b_reg;
    assign mag_r = neg_r ? (prev_r_reg - cur_r_reg) : (cur_r_reg - prev_r_reg);
    assign mag_g = neg_g ? (prev_g_reg - cur_g_reg) : (cur_g_reg - prev_g_reg);
    assign mag_b = neg_b ? (prev_b_reg - cur_b_reg) : (cur_b_reg - prev_b_reg);

    always_comb begin
        case (cmd.div_sel)
            DIV_BASE: begin
                dividend = DIV_W'(total);
                divisor  = LEN_W'(n_stops - CC_W'(1));
            end
            DIV_RED: begin
                dividend = mag_r;
                divisor  = len_reg;
            end
            DIV_GREEN: begin
                dividend = mag_g;
                divisor  = len_reg;
            end
            DIV_BLUE: begin
                dividend = mag_b;
                divisor  = len_reg;
            end
            default: begin
                dividend = mag_r;
                divisor  = len_reg;
            end
        endcase
    end

    cgr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_neg = ~quotient + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg   <= CC_W'(2);
            ec_reg   <= LEN_W'(MAX_ENTRIES);
            seen_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_COLOR_COUNT: cc_reg <= cfg_wr_data[CC_W-1:0];
                    REG_ENTRY_COUNT: ec_reg <= cfg_wr_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.take && status.first_stop)
                seen_reg <= SEEN_W'(1);
            else if (cmd.commit)
                seen_reg <= seen_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            cur_r_reg <= red_in;
            cur_g_reg <= green_in;
            cur_b_reg <= blue_in;
            if (status.first_stop) begin
                prev_r_reg <= red_in;
                prev_g_reg <= green_in;
                prev_b_reg <= blue_in;
            end
        end else if (cmd.commit) begin
            prev_r_reg <= cur_r_reg;
            prev_g_reg <= cur_g_reg;
            prev_b_reg <= cur_b_reg;
        end

        if (cmd.div_store) begin
            case (cmd.div_sel)
                DIV_BASE:  base_reg   <= quotient[LEN_W-1:0];
                DIV_RED:   step_r_reg <= neg_r ? q_neg : quotient;
                DIV_GREEN: step_g_reg <= neg_g ? q_neg : quotient;
                DIV_BLUE:  step_b_reg <= neg_b ? q_neg : quotient;
                default: ;
            endcase
        end

        if (cmd.seg_load) begin
            start_reg    <= start_c;
            len_reg      <= len_c;
            last_seg_reg <= last_seg_c;
        end

        if (cmd.emit_init) begin
            acc_r_reg  <= prev_r_reg + step_r_reg;
            acc_g_reg  <= prev_g_reg + step_g_reg;
            acc_b_reg  <= prev_b_reg + step_b_reg;
            idx_reg    <= start_reg[IDX_W-1:0];
            remain_reg <= len_reg;
        end else if (cmd.emit_next) begin
            acc_r_reg  <= acc_r_reg + step_r_reg;
            acc_g_reg  <= acc_g_reg + step_g_reg;
            acc_b_reg  <= acc_b_reg + step_b_reg;
            idx_reg    <= idx_reg + 1'b1;
            remain_reg <= remain_reg - 1'b1;
        end
    end

    assign status.first_stop = (seen_reg == '0) || (seen_reg >= n_stops);
    assign status.div_done   = div_done;
    assign status.len_zero   = len_c == '0;
    assign status.last_entry = remain_reg == LEN_W'(1);

    assign red_out      = acc_r_reg;
    assign green_out    = acc_g_reg;
    assign blue_out     = acc_b_reg;
    assign entry_index  = idx_reg;
    assign segment_end  = status.last_entry;
    assign gradient_end = last_seg_reg && status.last_entry;

endmodule

FILE: rtl/cgr_ctrl.sv
// ----------------------------------------------------------------------------
// cgr_ctrl
// Sequencer: takes a stop; after a gradient's first, runs the base division,
// then three step divisions and the entry stream if non-empty; commits it.
// ----------------------------------------------------------------------------
module cgr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  cgr_pkg::cgr_status_t status,
    output cgr_pkg::cgr_cmd_t    cmd
);
    import cgr_pkg::*;

    cgr_state_t   state_reg, state_next;
    cgr_div_sel_t sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_BASE;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (!status.first_stop) begin
                        sel_next   = DIV_BASE;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    case (sel_reg)
                        DIV_BASE: state_next = ST_SEG;
                        DIV_BLUE: state_next = ST_PREP;
                        default: begin
                            sel_next   = cgr_div_sel_t'(sel_reg + 2'd1);
                            state_next = ST_DIV_START;
                        end
                    endcase
                end
            end
            ST_SEG: begin
                cmd.seg_load = 1'b1;
                if (status.len_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    sel_next   = DIV_RED;
                    state_next = ST_DIV_START;
                end
            end
            ST_PREP: begin
                cmd.emit_init = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit_next = 1'b1;
                    if (status.last_entry)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/color_gradient_ramp_top.sv
// A first stop of a gradient is taken and emits nothing.
// Later stops: before the first entry is valid come the base-length divider pass, a segment
// load, the red, green and blue step divider passes, and a preload, in that order.
// Throughput: one entry per cycle while m_tready is high, then the stop is committed;
// s_tready stays low from a later stop's accept until its commit, also for a zero-length segment.
// Reset: aresetn synchronous, active low; color_count=2, entry_count=64.
// ----------------------------------------------------------------------------
// color_gradient_ramp_top
// Linear color ramp generator: one stream word per stop color in, one stream
// word per gradient entry out.
// ----------------------------------------------------------------------------
module color_gradient_ramp_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // red_out, green_out, blue_out, entry_index, pad
    output logic        m_tuser,  // segment_end
    output logic        m_tlast   // gradient_end
);
    import cgr_pkg::*;

    cgr_cmd_t          cmd;
    cgr_status_t       status;
    logic [CHAN_W-1:0] red_out, green_out, blue_out;
    logic [IDX_W-1:0]  entry_index;

    cgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cgr_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .red_in       (s_tdata[15:0]),
        .green_in     (s_tdata[31:16]),
        .blue_in      (s_tdata[47:32]),
        .cmd          (cmd),
        .status       (status),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .entry_index  (entry_index),
        .segment_end  (m_tuser),
        .gradient_end (m_tlast)
    );

    assign m_tdata = {2'b00, entry_index, blue_out, green_out, red_out};

endmodule
